// File: sv/cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cell bypass monitor: the input and
// result word layouts, channel codes, configuration register indexes and
// reset values.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Field widths fixed by the converter and the window sum.
  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 3;

  // Default number of cell-voltage samples in the moving window.
  localparam int WINDOW_DEF = 8;

  // Base used when the internal temperature is stored inverted.
  localparam logic [SAMPLE_W-1:0] INVERT_BASE = SAMPLE_W'(1000);

  // Register reset values.
  localparam logic [SUM_W-1:0]    HARD_LIMIT_RST  = '1;
  localparam logic [SUM_W-1:0]    BAL_LEVEL_RST   = '0;
  localparam logic [SAMPLE_W-1:0] TEMP_LIMIT_RST  = '1;
  localparam logic [SAMPLE_W-1:0] SAFETY_CUT_RST  = '1;
  localparam logic [SAMPLE_W-1:0] PROG_LEVEL_RST  = '1;

  // Channel codes carried in the op field.
  typedef enum logic [1:0] {
    OP_CELL     = 2'd0,
    OP_INT_TEMP = 2'd1,
    OP_EXT_TEMP = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HARD_LIMIT = 3'd0,
    CFG_BAL_LEVEL  = 3'd1,
    CFG_TEMP_LIMIT = 3'd2,
    CFG_SAFETY_CUT = 3'd3,
    CFG_PROG_LEVEL = 3'd4,
    CFG_INVERT     = 3'd5
  } cfg_idx_t;

  // Input word.
  typedef struct packed {
    logic [1:0]          op;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [SUM_W-1:0]    voltage_sum;
    logic [SAMPLE_W-1:0] internal_temp;
    logic [SAMPLE_W-1:0] external_temp;
    logic                bypass_request;
    logic                overheat;
    logic [15:0]         status_word;
  } out_word_t;

endpackage

// File: sv/cell_bypass_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_bypass_monitor_top
// Moving window sum of cell-voltage samples with threshold compares for
// bypass balancing and overheat, plus stored temperature readings.
// ----------------------------------------------------------------------------
// A result word is registered into the output buffer on the clock edge that
// accepts its input word. One word per cycle is accepted while the skid entry
// is empty, as the sample ring and the running sum are updated for each word.
// A two-entry output buffer takes one more input word while a result stalls.
// Synchronous active-low reset clears the ring, sum, readings and registers.
module cell_bypass_monitor_top #(
  parameter int WINDOW = cbm_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cbm_pkg::in_word_t                   in_word,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output cbm_pkg::out_word_t                  out_word,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbm_pkg::CFG_W-1:0]           cfg_wdata
);

  import cbm_pkg::*;

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int PROD_W = SAMPLE_W + $clog2(WINDOW + 1);
  localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  // Configuration registers
  logic [SUM_W-1:0]    hard_limit_r;
  logic [SUM_W-1:0]    bal_level_r;
  logic [SAMPLE_W-1:0] temp_limit_r;
  logic [SAMPLE_W-1:0] safety_cut_r;
  logic [SAMPLE_W-1:0] prog_level_r;
  logic                invert_r;

  // Datapath state
  logic [SAMPLE_W-1:0] ring_r [WINDOW];
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    total_r, total_nxt;
  logic [SAMPLE_W-1:0] int_temp_r, int_temp_nxt;
  logic [SAMPLE_W-1:0] ext_temp_r, ext_temp_nxt;
  logic                ring_we;

  // Output buffer: main register drives the port, skid catches one more word
  logic      main_valid_r, skid_valid_r;
  out_word_t main_word_r, skid_word_r;
  out_word_t result;

  logic in_acc, out_take;
  logic [CMP_W-1:0] prog_sum;
  logic [CMP_W-1:0] sum_ext;
  logic byp, hot;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_word_r;
  assign out_take  = main_valid_r && !out_stall;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_limit_r <= HARD_LIMIT_RST;
      bal_level_r  <= BAL_LEVEL_RST;
      temp_limit_r <= TEMP_LIMIT_RST;
      safety_cut_r <= SAFETY_CUT_RST;
      prog_level_r <= PROG_LEVEL_RST;
      invert_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HARD_LIMIT: hard_limit_r <= cfg_wdata[SUM_W-1:0];
        CFG_BAL_LEVEL:  bal_level_r  <= cfg_wdata[SUM_W-1:0];
        CFG_TEMP_LIMIT: temp_limit_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_SAFETY_CUT: safety_cut_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_PROG_LEVEL: prog_level_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_INVERT:     invert_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next state for the incoming word, by channel.
  always_comb begin
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    int_temp_nxt = int_temp_r;
    ext_temp_nxt = ext_temp_r;
    ring_we      = 1'b0;
    unique case (op_t'(in_word.op))
      OP_CELL: begin
        ring_we   = 1'b1;
        total_nxt = total_r - SUM_W'(ring_r[pos_r]) + SUM_W'(in_word.sample);
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
      end
      OP_INT_TEMP: begin
        if (!invert_r) begin
          int_temp_nxt = in_word.sample;
        end else if (in_word.sample > INVERT_BASE) begin
          int_temp_nxt = '0;
        end else begin
          int_temp_nxt = INVERT_BASE - in_word.sample;
        end
      end
      OP_EXT_TEMP: ext_temp_nxt = in_word.sample;
      default: ;
    endcase
  end

  // Threshold compares on the updated state.
  always_comb begin
    prog_sum = CMP_W'(prog_level_r) * CMP_W'(WINDOW);
    sum_ext  = CMP_W'(total_nxt);
    if (sum_ext >= prog_sum) begin
      byp = 1'b0;
    end else if (bal_level_r != '0 && total_nxt > bal_level_r) begin
      byp = 1'b1;
    end else begin
      byp = (total_nxt > hard_limit_r);
    end
    hot = (int_temp_nxt > temp_limit_r) || (int_temp_nxt > safety_cut_r);

    result.voltage_sum    = total_nxt;
    result.internal_temp  = int_temp_nxt;
    result.external_temp  = ext_temp_nxt;
    result.bypass_request = byp;
    result.overheat       = hot;
    result.status_word    = {byp, hot, total_nxt};
  end

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
      pos_r      <= '0;
      total_r    <= '0;
      int_temp_r <= '0;
      ext_temp_r <= '0;
    end else if (in_acc) begin
      if (ring_we) begin
        ring_r[pos_r] <= in_word.sample;
      end
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      int_temp_r <= int_temp_nxt;
      ext_temp_r <= ext_temp_nxt;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (main_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      main_valid_r <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        main_word_r <= skid_word_r;
      end
    end else if (in_acc) begin
      if (main_valid_r && !out_take) begin
        skid_word_r <= result;
      end else begin
        main_word_r <= result;
      end
    end
  end

endmodule

// File: test/cell_bypass_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_bypass_monitor_top_tb
// Self-checking bench for the cell bypass monitor. A clocked driver sends
// sample words from a queue, and a clocked monitor predicts every report word
// and compares it, field by field, with the words that the block returns.
// The run steps through several register settings, random gaps on the input
// channel and random stall patterns on the result channel.
// ----------------------------------------------------------------------------
module cell_bypass_monitor_top_tb;
  import cbm_pkg::*;

  localparam int          WINDOW      = WINDOW_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  cell_bypass_monitor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Register copies kept by the predictor.
  logic [SUM_W-1:0]    lim_hard;
  logic [SUM_W-1:0]    lim_balance;
  logic [SAMPLE_W-1:0] lim_temp;
  logic [SAMPLE_W-1:0] lim_safety;
  logic [SAMPLE_W-1:0] lim_prog;
  logic                invert_int;

  // Predicted block state.
  logic [SAMPLE_W-1:0] cell_ring [WINDOW];
  int                  ring_pos;
  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] int_reading;
  logic [SAMPLE_W-1:0] ext_reading;

  in_word_t    pending_samples [$];
  out_word_t   expected_reports [$];
  int unsigned queued_words;
  int unsigned accepted_words;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          sender_steady;
  int          hold_requests;

  task automatic reset_model();
    lim_hard    = HARD_LIMIT_RST;
    lim_balance = BAL_LEVEL_RST;
    lim_temp    = TEMP_LIMIT_RST;
    lim_safety  = SAFETY_CUT_RST;
    lim_prog    = PROG_LEVEL_RST;
    invert_int  = 1'b0;
    foreach (cell_ring[i]) cell_ring[i] = '0;
    ring_pos    = 0;
    window_sum  = '0;
    int_reading = '0;
    ext_reading = '0;
  endtask

  // Applies one sample word to the predicted state and builds its report.
  function automatic out_word_t predict_cell_report(in_word_t w);
    out_word_t   rep;
    int unsigned level_sum;
    logic        byp;
    logic        hot;
    case (w.op)
      OP_CELL: begin
        window_sum          = window_sum - cell_ring[ring_pos] + w.sample;
        cell_ring[ring_pos] = w.sample;
        ring_pos            = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
      end
      OP_INT_TEMP: begin
        if (!invert_int)
          int_reading = w.sample;
        else if (w.sample > INVERT_BASE)
          int_reading = '0;
        else
          int_reading = INVERT_BASE - w.sample;
      end
      OP_EXT_TEMP: ext_reading = w.sample;
      default: ;
    endcase
    // A sum at or above the programmer level times the window never asks for bypass.
    level_sum = lim_prog * WINDOW;
    if (window_sum >= level_sum)
      byp = 1'b0;
    else if (lim_balance != '0 && window_sum > lim_balance)
      byp = 1'b1;
    else
      byp = (window_sum > lim_hard);
    hot = (int_reading > lim_temp) || (int_reading > lim_safety);
    rep.voltage_sum    = window_sum;
    rep.internal_temp  = int_reading;
    rep.external_temp  = ext_reading;
    rep.bypass_request = byp;
    rep.overheat       = hot;
    rep.status_word    = {byp, hot, window_sum};
    return rep;
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] near(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  task automatic queue_word(logic [1:0] op, logic [SAMPLE_W-1:0] s);
    in_word_t w;
    w.op     = op;
    w.sample = s;
    pending_samples.push_back(w);
    queued_words++;
  endtask

  // Register write; the predictor copy changes with it, while the block idles.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_HARD_LIMIT: lim_hard    = value;
      CFG_BAL_LEVEL:  lim_balance = value;
      CFG_TEMP_LIMIT: lim_temp    = value[SAMPLE_W-1:0];
      CFG_SAFETY_CUT: lim_safety  = value[SAMPLE_W-1:0];
      CFG_PROG_LEVEL: lim_prog    = value[SAMPLE_W-1:0];
      CFG_INVERT:     invert_int  = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int hard, int bal, int tlim, int safe, int prog, int inv);
    set_reg(CFG_HARD_LIMIT, CFG_W'(hard));
    set_reg(CFG_BAL_LEVEL, CFG_W'(bal));
    set_reg(CFG_TEMP_LIMIT, CFG_W'(tlim));
    set_reg(CFG_SAFETY_CUT, CFG_W'(safe));
    set_reg(CFG_PROG_LEVEL, CFG_W'(prog));
    set_reg(CFG_INVERT, CFG_W'(inv));
    // Writes to the spare indexes must leave every register alone.
    set_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
    @(negedge clk);
  endtask

  // Waits until every word has gone in and every report has come back.
  task automatic drain();
    while (accepted_words != queued_words || expected_reports.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Random words, with cell samples clustered around a threshold of interest.
  task automatic random_phase(int count);
    int               centre;
    int               r;
    logic [1:0]       op;
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 3))
      0:       centre = lim_hard / WINDOW;
      1:       centre = (lim_balance != '0) ? lim_balance / WINDOW : lim_prog;
      2:       centre = lim_prog;
      default: centre = $urandom_range(0, 1023);
    endcase
    if (centre > 1023) centre = 1023;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        op = OP_CELL;
        s  = ($urandom_range(0, 9) < 7) ? near(centre, 24) : SAMPLE_W'($urandom);
      end else if (r < 78) begin
        op = OP_INT_TEMP;
        case ($urandom_range(0, 3))
          0:       s = near(lim_temp, 6);
          1:       s = near(lim_safety, 6);
          2:       s = near(INVERT_BASE, 6);
          default: s = SAMPLE_W'($urandom);
        endcase
      end else if (r < 93) begin
        op = OP_EXT_TEMP;
        s  = SAMPLE_W'($urandom);
      end else begin
        op = OP_UNUSED;
        s  = SAMPLE_W'($urandom);
      end
      queue_word(op, s);
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: holds a stalled word, otherwise idles out its gap or sends the next.
  always @(posedge clk) begin : sample_driver
    int         gap_left;
    logic       nxt_valid;
    in_word_t   nxt_word;
    nxt_valid = in_valid;
    nxt_word  = in_word;
    if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_valid = 1'b0;
      end else if (rst_n && pending_samples.size() != 0) begin
        nxt_word  = pending_samples.pop_front();
        nxt_valid = 1'b1;
        gap_left  = sender_steady ? 0 : pick_gap();
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
    in_word  <= nxt_word;
  end

  // Receiver: free-running stretches, random stalls and the occasional long hold.
  always @(posedge clk) begin : report_stall
    int   hold_left;
    int   holds_served;
    int   stall_left;
    int   flow_left;
    logic nxt;
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      nxt = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      nxt = 1'b0;
    end else begin
      flow_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 6);
      stall_left = pick_gap();
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  // Monitor: checks the oldest expectation first, then predicts the new word.
  always @(posedge clk) begin : report_monitor
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected report word: status %0d", out_word.status_word);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("voltage_sum", want.voltage_sum, out_word.voltage_sum);
          check_field("internal_temp", want.internal_temp, out_word.internal_temp);
          check_field("external_temp", want.external_temp, out_word.external_temp);
          check_field("bypass_request", want.bypass_request, out_word.bypass_request);
          check_field("overheat", want.overheat, out_word.overheat);
          check_field("status_word", want.status_word, out_word.status_word);
        end
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_cell_report(in_word));
        accepted_words++;
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset settings: field extremes and every channel.
    queue_word(OP_UNUSED, 10'h000);
    for (int i = 0; i < WINDOW; i++) queue_word(OP_CELL, 10'h3FF);
    queue_word(OP_CELL, 10'h000);
    queue_word(OP_CELL, 10'h2AA);
    queue_word(OP_CELL, 10'h155);
    queue_word(OP_INT_TEMP, 10'h000);
    queue_word(OP_INT_TEMP, 10'h3FF);
    queue_word(OP_EXT_TEMP, 10'h3FF);
    queue_word(OP_EXT_TEMP, 10'h155);
    queue_word(OP_UNUSED, 10'h3FF);
    drain();

    // Inverted internal temperature, including readings above the base.
    apply_settings(16383, 300, 500, 1023, 60, 1);
    queue_word(OP_INT_TEMP, 10'd1000);
    queue_word(OP_INT_TEMP, 10'd1001);
    queue_word(OP_INT_TEMP, 10'h3FF);
    queue_word(OP_INT_TEMP, 10'd0);
    queue_word(OP_CELL, 10'd20);
    queue_word(OP_INT_TEMP, 10'd999);
    queue_word(OP_CELL, 10'd100);
    drain();

    // Random phases over a range of settings, the extremes first.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, 0, 0, 1);
        1: apply_settings(16383, 16383, 1023, 1023, 1023, 0);
        2: apply_settings($urandom_range(0, 8300), 0, 1023, $urandom_range(0, 1023), 1023, 0);
        default: apply_settings($urandom_range(0, 8500),
                                $urandom_range(0, 1) ? 0 : $urandom_range(1, 8500),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1) ? 1023 : $urandom_range(0, 1023),
                                $urandom_range(0, 1));
      endcase
      sender_steady = (p == 3 || p == 7 || p == 8);
      if (p == 3 || p == 7)
        hold_requests++;
      random_phase(160);
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
sv/cbm_pkg.sv
sv/cell_bypass_monitor_top.sv
test/cell_bypass_monitor_top_tb.sv
